// File: rtl/core/vaar_pkg.sv
package vaar_pkg;

	// Fraction bits of the unit-axis, sin and cos values (Q2.30).
	localparam int FRAC = 30;

	// Width of a signed unit-axis component or a sin/cos value.
	localparam int UW = 32;

	// Rotation stages of the sin/cos unit and its working width.
	localparam int CORDIC_ITERS = 30;
	localparam int CORDIC_W = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

	localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	// Working state of one sin/cos rotation stage.
	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
		logic                       flip;
	} cordic_st_t;

endpackage

// File: rtl/core/vaar_delay.sv
module vaar_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [DEPTH];

	always_ff @(posedge clk) begin
		pipe_q[0] <= d;
		for (int k = 1; k < DEPTH; k++) begin
			pipe_q[k] <= pipe_q[k-1];
		end
	end

	assign q = pipe_q[DEPTH-1];

endmodule

// File: rtl/core/vaar_mulr.sv
module vaar_mulr import vaar_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int OW = 33
) (
	input  logic                 clk,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [OW-1:0] y
);

	localparam int PW = AW + BW;

	logic [AW-1:0]   am;
	logic [BW-1:0]   bm;
	logic [PW-1:0]   prod_s1;
	logic            neg_s1;
	logic [PW-1:0]   rnd;
	logic [PW-1:0]   mag;
	logic signed [PW:0] sv;

	// Sign-magnitude product so that halves round away from zero.
	assign am = a[AW-1] ? AW'(-a) : AW'(a);
	assign bm = b[BW-1] ? BW'(-b) : BW'(b);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(am) * PW'(bm);
		neg_s1  <= a[AW-1] ^ b[BW-1];
	end

	assign rnd = prod_s1 + (PW'(1) << (FRAC - 1));
	assign mag = rnd >> FRAC;
	assign sv  = neg_s1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	always_ff @(posedge clk) begin
		y <= sv[OW-1:0];
	end

endmodule

// File: rtl/core/vaar_isqrt.sv
module vaar_isqrt (
	input  logic        clk,
	input  logic [61:0] v,
	output logic [30:0] root
);

	localparam int STAGES = 31;

	logic [61:0] rem_s [STAGES];
	logic [61:0] res_s [STAGES];

	// One root bit per stage, trial bit from 2^60 down to 2^0.
	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
		logic [61:0] rem_in;
		logic [61:0] res_in;
		logic [61:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = v;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_s[k] <= rem_in - trial;
				res_s[k] <= (res_in >> 1) + BIT;
			end else begin
				rem_s[k] <= rem_in;
				res_s[k] <= res_in >> 1;
			end
		end
	end

	assign root = res_s[STAGES-1][30:0];

endmodule

// File: rtl/core/vaar_div.sv
module vaar_div (
	input  logic        clk,
	input  logic [60:0] num,
	input  logic [30:0] den,
	output logic [30:0] quo
);

	localparam int STAGES = 31;

	logic [60:0] rem_s [STAGES];
	logic [30:0] den_s [STAGES];
	logic [30:0] quo_s [STAGES];

	// Restoring division, quotient bit 30 first.
	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		localparam int B = 30 - j;
		logic [60:0] rem_in;
		logic [30:0] den_in;
		logic [30:0] quo_in;
		logic [60:0] dsh;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		assign dsh = 61'(den_in) << B;

		always_ff @(posedge clk) begin
			den_s[j] <= den_in;
			if (rem_in >= dsh) begin
				rem_s[j] <= rem_in - dsh;
				quo_s[j] <= quo_in | (31'(1) << B);
			end else begin
				rem_s[j] <= rem_in;
				quo_s[j] <= quo_in;
			end
		end
	end

	assign quo = quo_s[STAGES-1];

endmodule

// File: rtl/core/vaar_cordic.sv
module vaar_cordic import vaar_pkg::*; #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                   clk,
	input  logic [ANGLE_WIDTH-1:0] angle,
	output logic signed [UW-1:0]   sn,
	output logic signed [UW-1:0]   cs
);

	logic [31:0] a_full;
	logic [31:0] a_turn;
	logic [31:0] a_fold;
	logic        flip;

	cordic_st_t st_s [CORDIC_ITERS+1];

	// Second and third quadrants are turned by half a turn first.
	assign a_full = 32'(angle) << (32 - ANGLE_WIDTH);
	assign a_turn = a_full + 32'h4000_0000;
	assign flip   = a_turn[31];
	assign a_fold = flip ? (a_full ^ 32'h8000_0000) : a_full;

	always_ff @(posedge clk) begin
		st_s[0].x    <= CORDIC_START;
		st_s[0].y    <= '0;
		st_s[0].z    <= CORDIC_W'($signed(a_fold));
		st_s[0].flip <= flip;
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		localparam logic signed [CORDIC_W-1:0] ATN =
			$signed({{(CORDIC_W-32){1'b0}}, ATAN_TAB[i]});

		always_ff @(posedge clk) begin
			st_s[i+1].flip <= st_s[i].flip;
			if (!st_s[i].z[CORDIC_W-1]) begin
				st_s[i+1].x <= st_s[i].x - (st_s[i].y >>> i);
				st_s[i+1].y <= st_s[i].y + (st_s[i].x >>> i);
				st_s[i+1].z <= st_s[i].z - ATN;
			end else begin
				st_s[i+1].x <= st_s[i].x + (st_s[i].y >>> i);
				st_s[i+1].y <= st_s[i].y - (st_s[i].x >>> i);
				st_s[i+1].z <= st_s[i].z + ATN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_s[CORDIC_ITERS].flip) begin
			cs <= UW'(-st_s[CORDIC_ITERS].x);
			sn <= UW'(-st_s[CORDIC_ITERS].y);
		end else begin
			cs <= UW'(st_s[CORDIC_ITERS].x);
			sn <= UW'(st_s[CORDIC_ITERS].y);
		end
	end

endmodule

// File: rtl/core/vector_axis_angle_rotate.sv
// Latency: 78 register stages; done rises in the same cycle that the result appears
// on res_x, res_y, res_z, zero_axis and overflow.
// Throughput: one item per cycle; the datapath is a fixed pipeline, busy stays low.
// The result ports hold each result for one cycle; the receiver cannot stall.
// Reset (arst_n low, asynchronous) clears the valid chain only, so no spurious
// done follows reset; payload registers are not reset.
module vector_axis_angle_rotate import vaar_pkg::*; #(
	parameter int COMP_WIDTH  = 32,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COMP_WIDTH-1:0] vec_x,
	input  logic signed [COMP_WIDTH-1:0] vec_y,
	input  logic signed [COMP_WIDTH-1:0] vec_z,
	input  logic signed [COMP_WIDTH-1:0] axis_x,
	input  logic signed [COMP_WIDTH-1:0] axis_y,
	input  logic signed [COMP_WIDTH-1:0] axis_z,
	input  logic [ANGLE_WIDTH-1:0]       angle,
	output logic                         done,
	output logic signed [COMP_WIDTH-1:0] res_x,
	output logic signed [COMP_WIDTH-1:0] res_y,
	output logic signed [COMP_WIDTH-1:0] res_z,
	output logic                         zero_axis,
	output logic                         overflow
);

	localparam int CW  = COMP_WIDTH;
	localparam int BLW = $clog2(CW + 1);

	// Stage numbers, counted in register stages after acceptance.
	localparam int ST_MAG     = 2;
	localparam int ST_BL      = 3;
	localparam int ST_M       = 4;
	localparam int ISQ_LAT    = 31;
	localparam int DIV_LAT    = 31;
	localparam int MUL_LAT    = 2;
	localparam int CORDIC_LAT = 32;
	localparam int ST_SUM     = 6;
	localparam int ST_LEN     = ST_SUM + ISQ_LAT;
	localparam int ST_Q       = ST_LEN + DIV_LAT;
	localparam int ST_U       = ST_Q + 1;
	localparam int ST_S       = ST_U + MUL_LAT + 1;
	localparam int ST_C       = ST_S + MUL_LAT + 1;
	localparam int ST_P3      = ST_C + MUL_LAT;
	localparam int ST_R       = ST_P3 + 1;

	// The pipeline never stops, so the block is never busy.
	assign busy = 1'b0;

	// Valid chain: one bit per stage, cleared by reset.
	logic [ST_R-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[ST_R-2:0], start & ~busy};
		end
	end

	assign done = vld_q[ST_R-1];

	// Stage 1: capture the item.
	logic signed [CW-1:0]  vec_s1  [3];
	logic signed [CW-1:0]  axis_s1 [3];
	logic [ANGLE_WIDTH-1:0] ang_s1;

	always_ff @(posedge clk) begin
		vec_s1[0]  <= vec_x;
		vec_s1[1]  <= vec_y;
		vec_s1[2]  <= vec_z;
		axis_s1[0] <= axis_x;
		axis_s1[1] <= axis_y;
		axis_s1[2] <= axis_z;
		ang_s1     <= angle;
	end

	// Stage 2: axis magnitudes and signs.
	logic [CW-1:0] mag_s2 [3];
	logic          neg_s2 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s2[i] <= axis_s1[i][CW-1] ? CW'(-axis_s1[i]) : CW'(axis_s1[i]);
			neg_s2[i] <= axis_s1[i][CW-1];
		end
	end

	// Stage 3: bit length of the largest magnitude. A length of zero means the
	// axis has zero length.
	logic [CW-1:0]  big;
	logic [BLW-1:0] bl;
	logic [CW-1:0]  mag_s3 [3];
	logic [BLW-1:0] bl_s3;
	logic           zero_s3;

	always_comb begin
		big = mag_s2[0];
		if (mag_s2[1] > big) begin
			big = mag_s2[1];
		end
		if (mag_s2[2] > big) begin
			big = mag_s2[2];
		end
		bl = '0;
		for (int k = 0; k < CW; k++) begin
			if (big[k]) begin
				bl = BLW'(k + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s3  <= mag_s2;
		bl_s3   <= bl;
		zero_s3 <= (big == '0);
	end

	// Stage 4: scale all magnitudes by one power of two so the largest lies in
	// [2^29, 2^30). Appending 30 zeros and shifting right by the bit length
	// covers both directions, and right shifts truncate.
	logic [29:0] m_s4 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s4[i] <= 30'({mag_s3[i], 30'b0} >> bl_s3);
		end
	end

	// Stages 5 and 6: squared length.
	logic [59:0] sq_s5 [3];
	logic [61:0] sum_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= 60'(m_s4[i]) * 60'(m_s4[i]);
		end
		sum_s6 <= 62'(sq_s5[0]) + 62'(sq_s5[1]) + 62'(sq_s5[2]);
	end

	// Axis length, one root bit per stage.
	logic [30:0] len;

	vaar_isqrt u_isqrt (
		.clk  (clk),
		.v    (sum_s6),
		.root (len)
	);

	// Unit components: (m * 2^30 + floor(L/2)) / L, then the axis sign. A zero
	// axis gives a meaningless quotient here; the final stage forces zero.
	logic signed [CW-1:0]  v_d   [3];
	logic signed [UW-1:0]  u_s69 [3];

	for (genvar i = 0; i < 3; i++) begin : g_unit
		logic [29:0] m_d;
		logic        neg_d;
		logic [60:0] num;
		logic [30:0] q;

		vaar_delay #(.W(30), .DEPTH(ST_LEN - ST_M)) u_dly_m (
			.clk (clk),
			.d   (m_s4[i]),
			.q   (m_d)
		);

		vaar_delay #(.W(1), .DEPTH(ST_Q - ST_MAG)) u_dly_neg (
			.clk (clk),
			.d   (neg_s2[i]),
			.q   (neg_d)
		);

		vaar_delay #(.W(CW), .DEPTH(ST_U - 1)) u_dly_v (
			.clk (clk),
			.d   (vec_s1[i]),
			.q   (v_d[i])
		);

		assign num = 61'({m_d, 30'b0}) + 61'(len >> 1);

		vaar_div u_div (
			.clk (clk),
			.num (num),
			.den (len),
			.quo (q)
		);

		always_ff @(posedge clk) begin
			u_s69[i] <= neg_d ? -$signed({1'b0, q}) : $signed({1'b0, q});
		end
	end

	// Sin and cos of the angle run beside the axis path and wait for it.
	logic signed [UW-1:0] sn;
	logic signed [UW-1:0] cs;
	logic signed [UW-1:0] sn_d;
	logic signed [UW-1:0] cs_d;

	vaar_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
		.clk   (clk),
		.angle (ang_s1),
		.sn    (sn),
		.cs    (cs)
	);

	vaar_delay #(.W(UW), .DEPTH(ST_C - 1 - CORDIC_LAT)) u_dly_sn (
		.clk (clk),
		.d   (sn),
		.q   (sn_d)
	);

	vaar_delay #(.W(UW), .DEPTH(ST_C - 1 - CORDIC_LAT)) u_dly_cs (
		.clk (clk),
		.d   (cs),
		.q   (cs_d)
	);

	// First product rank: the dot product n.v and the cross product s = n x v.
	// Each rounded term is bounded by |v|, so it fits one bit more than v.
	logic signed [CW:0]   dot_p [3];
	logic signed [CW:0]   sa_p  [3];
	logic signed [CW:0]   sb_p  [3];
	logic signed [CW+1:0] vn_s72;
	logic signed [CW+1:0] s_s72 [3];

	for (genvar i = 0; i < 3; i++) begin : g_rank1
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;

		vaar_mulr #(.AW(UW), .BW(CW), .OW(CW + 1)) u_mul_dot (
			.clk (clk), .a (u_s69[i]), .b (v_d[i]), .y (dot_p[i])
		);
		vaar_mulr #(.AW(UW), .BW(CW), .OW(CW + 1)) u_mul_sa (
			.clk (clk), .a (u_s69[I1]), .b (v_d[I2]), .y (sa_p[i])
		);
		vaar_mulr #(.AW(UW), .BW(CW), .OW(CW + 1)) u_mul_sb (
			.clk (clk), .a (u_s69[I2]), .b (v_d[I1]), .y (sb_p[i])
		);

		always_ff @(posedge clk) begin
			s_s72[i] <= (CW + 2)'(sa_p[i]) - (CW + 2)'(sb_p[i]);
		end
	end

	always_ff @(posedge clk) begin
		vn_s72 <= (CW + 2)'(dot_p[0]) + (CW + 2)'(dot_p[1]) + (CW + 2)'(dot_p[2]);
	end

	// Second product rank: c = s x n and the parallel term n * (n.v).
	logic signed [UW-1:0] u_d72 [3];
	logic signed [CW+1:0] ca_p  [3];
	logic signed [CW+1:0] cb_p  [3];
	logic signed [CW+1:0] w_p   [3];
	logic signed [CW+2:0] c_s75 [3];
	logic signed [CW+1:0] w_s75 [3];

	for (genvar i = 0; i < 3; i++) begin : g_rank2
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;

		vaar_delay #(.W(UW), .DEPTH(ST_S - ST_U)) u_dly_u (
			.clk (clk),
			.d   (u_s69[i]),
			.q   (u_d72[i])
		);

		vaar_mulr #(.AW(CW + 2), .BW(UW), .OW(CW + 2)) u_mul_ca (
			.clk (clk), .a (s_s72[I1]), .b (u_d72[I2]), .y (ca_p[i])
		);
		vaar_mulr #(.AW(CW + 2), .BW(UW), .OW(CW + 2)) u_mul_cb (
			.clk (clk), .a (s_s72[I2]), .b (u_d72[I1]), .y (cb_p[i])
		);
		vaar_mulr #(.AW(CW + 2), .BW(UW), .OW(CW + 2)) u_mul_w (
			.clk (clk), .a (vn_s72), .b (u_d72[i]), .y (w_p[i])
		);

		always_ff @(posedge clk) begin
			c_s75[i] <= (CW + 3)'(ca_p[i]) - (CW + 3)'(cb_p[i]);
			w_s75[i] <= w_p[i];
		end
	end

	// Third product rank and the final sum with saturation.
	logic signed [CW+1:0] s_d75 [3];
	logic signed [CW+3:0] tc_p  [3];
	logic signed [CW+2:0] ts_p  [3];
	logic signed [CW+1:0] w_d77 [3];
	logic                 zero_d;
	logic signed [CW+5:0] lim_hi;
	logic signed [CW+5:0] lim_lo;
	logic signed [CW-1:0] res_q [3];
	logic [2:0]           sat;
	logic                 zero_q;
	logic                 ovf_q;

	assign lim_hi = {{7{1'b0}}, {(CW - 1){1'b1}}};
	assign lim_lo = {{7{1'b1}}, {(CW - 1){1'b0}}};

	vaar_delay #(.W(1), .DEPTH(ST_P3 - ST_BL)) u_dly_zero (
		.clk (clk),
		.d   (zero_s3),
		.q   (zero_d)
	);

	for (genvar i = 0; i < 3; i++) begin : g_rank3
		logic signed [CW+5:0] total;

		vaar_delay #(.W(CW + 2), .DEPTH(ST_C - ST_S)) u_dly_s (
			.clk (clk),
			.d   (s_s72[i]),
			.q   (s_d75[i])
		);

		vaar_delay #(.W(CW + 2), .DEPTH(ST_P3 - ST_C)) u_dly_w (
			.clk (clk),
			.d   (w_s75[i]),
			.q   (w_d77[i])
		);

		vaar_mulr #(.AW(CW + 3), .BW(UW), .OW(CW + 4)) u_mul_tc (
			.clk (clk), .a (c_s75[i]), .b (cs_d), .y (tc_p[i])
		);
		vaar_mulr #(.AW(CW + 2), .BW(UW), .OW(CW + 3)) u_mul_ts (
			.clk (clk), .a (s_d75[i]), .b (sn_d), .y (ts_p[i])
		);

		assign total = (CW + 6)'(tc_p[i]) + (CW + 6)'(ts_p[i]) + (CW + 6)'(w_d77[i]);
		assign sat[i] = (total > lim_hi) || (total < lim_lo);

		// A zero axis forces a zero result; otherwise clamp to the signed range.
		always_ff @(posedge clk) begin
			priority if (zero_d) begin
				res_q[i] <= '0;
			end else if (total > lim_hi) begin
				res_q[i] <= lim_hi[CW-1:0];
			end else if (total < lim_lo) begin
				res_q[i] <= lim_lo[CW-1:0];
			end else begin
				res_q[i] <= total[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		zero_q <= zero_d;
		ovf_q  <= ~zero_d & (|sat);
	end

	assign res_x     = res_q[0];
	assign res_y     = res_q[1];
	assign res_z     = res_q[2];
	assign zero_axis = zero_q;
	assign overflow  = ovf_q;

endmodule
